// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== rtl/core/dfpm_pkg.sv =====
package dfpm_pkg;

   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_PULSE    = 3'd1;
   localparam logic [2:0] CMD_READ     = 3'd2;
   localparam logic [2:0] CMD_SUBTRACT = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   localparam logic CSR_DIVIDER_FIRST  = 1'b0;
   localparam logic CSR_DIVIDER_SECOND = 1'b1;

   localparam int DIVIDER_COUNT = 2;

   localparam logic [31:0] STALE_MS      = 32'd1000;
   localparam int          NUM_W         = 20;
   localparam logic [NUM_W-1:0] RATE_SCALE = NUM_W'(1000000);
   localparam logic [15:0] DIVIDER_RESET = 16'd450;
   localparam logic [15:0] RATE_MAX      = 16'hFFFF;

   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_mul;
      logic div_step;
      logic load_out;
   } dfpm_cmd_type;

   typedef struct packed {
      logic skip;
   } dfpm_status_type;

endpackage

// ===== rtl/core/dual_flow_pulse_meter_top.sv =====
// Two-sensor pulse-period flow meter.
// Request channel (req_valid / req_stall): each transfer carries a command
// (tick, pulse, read, subtract, clear), a sensor number from zero and an
// amount used by subtract. Every request gives exactly one response transfer
// on rsp_valid / rsp_stall: rate in ml/s of the addressed sensor, its pulse
// count after the command, and an underflow flag for a clamped subtract.
// The csr port writes the pulses-per-litre divider of sensor zero (index 0)
// or sensor one (index 1); a zero write is ignored. A request passes through
// execute, multiply, 20 divider steps and one output load when the rate is
// live; the divider steps are skipped when the rate is zero (stale, out of
// range, or too slow to register). One request is in the controller at a
// time: a new one is taken only once the last result has left it, and the
// 20-step restoring divider is the longest part of that work.
// A finished response sits in the output register, and a new request is
// taken while it waits; if the receiver stalls, the next result holds in the
// controller until the output register frees.
// Reset: clock, counters and intervals clear to zero, dividers return to 450,
// no response is pending.
module dual_flow_pulse_meter_top #(
   parameter int SENSOR_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic        req_sensor,
   input  logic [31:0] req_amount,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_rate_ml_per_s,
   output logic [31:0] rsp_pulse_count,
   output logic        rsp_underflow,
   // configuration writes
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import dfpm_pkg::*;

   dfpm_cmd_type    cmd;
   dfpm_status_type status;

   // sequencing: accept, execute, set up, divide, load output
   dfpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // meter state, rate multiplier, serial divider and response registers
   dfpm_dp #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_sensor        (req_sensor),
      .req_amount        (req_amount),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_rate_ml_per_s (rsp_rate_ml_per_s),
      .rsp_pulse_count   (rsp_pulse_count),
      .rsp_underflow     (rsp_underflow)
   );

endmodule

// ===== rtl/core/dfpm_ctrl.sv =====
`include "assert_macros.svh"

module dfpm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  dfpm_pkg::dfpm_status_type status,
   output dfpm_pkg::dfpm_cmd_type    cmd
);
   import dfpm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_mul = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (status.skip) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + 1'b1;
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_PROP(a_accept_to_exec, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
   `ASSERT_PROP(a_load_when_free, clock, reset, cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
   `ASSERT_PROP(a_step_range, clock, reset, (state_ff == ST_DIV) |-> (step_ff < STEP_W'(DIV_STEPS)))
   `ASSERT_NEVER(a_no_step_on_skip, clock, reset, cmd.div_step && status.skip)

endmodule

// ===== rtl/core/dfpm_dp.sv =====
module dfpm_dp #(
   parameter int SENSOR_COUNT = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dfpm_pkg::dfpm_cmd_type    cmd,
   output dfpm_pkg::dfpm_status_type status,
   input  logic [2:0]                req_cmd,
   input  logic                      req_sensor,
   input  logic [31:0]               req_amount,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [15:0]               csr_data,
   output logic [15:0]               rsp_rate_ml_per_s,
   output logic [31:0]               rsp_pulse_count,
   output logic                      rsp_underflow
);
   import dfpm_pkg::*;

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   // Captured item
   logic [2:0]  item_cmd_ff;
   logic        item_sensor_ff;
   logic [31:0] item_amount_ff;

   // Meter state
   logic [31:0] now_ms_ff, now_ms_in;
   logic [31:0] last_ff     [SENSOR_COUNT];
   logic [31:0] interval_ff [SENSOR_COUNT];
   logic [31:0] total_ff    [SENSOR_COUNT];
   logic [15:0] divider_ff  [DIVIDER_COUNT];

   logic [IDX_W-1:0] idx;
   logic             in_range;
   logic [31:0]      cur_last, cur_interval, cur_total;
   logic [15:0]      cur_divider;

   logic        state_we;
   logic [31:0] last_in, interval_in, total_in;
   logic        under_ff, under_in;

   // Rate path
   logic [31:0]      age, interval_eff;
   logic [47:0]      prod_ff, prod_in;
   logic             gate_ff, gate_in;
   logic [31:0]      count_ff;
   logic             under_hold_ff;
   logic [NUM_W-1:0] rem_ff, quo_ff;
   logic [NUM_W:0]   trial, divisor;
   logic [15:0]      rate_sat;

   assign idx      = IDX_W'(item_sensor_ff);
   assign in_range = (32'(item_sensor_ff) < 32'(SENSOR_COUNT));

   assign cur_last     = last_ff[idx];
   assign cur_interval = interval_ff[idx];
   assign cur_total    = total_ff[idx];
   assign cur_divider  = divider_ff[item_sensor_ff];

   // Item execution
   always_comb begin
      now_ms_in   = now_ms_ff;
      state_we    = 1'b0;
      last_in     = cur_last;
      interval_in = cur_interval;
      total_in    = cur_total;
      under_in    = 1'b0;
      if (cmd.exec && item_cmd_ff == CMD_TICK) begin
         now_ms_in = now_ms_ff + 32'd1;
      end
      if (cmd.exec && in_range) begin
         unique case (item_cmd_ff)
            CMD_PULSE: begin
               state_we    = 1'b1;
               total_in    = cur_total + 32'd1;
               interval_in = now_ms_ff - cur_last;
               last_in     = now_ms_ff;
            end
            CMD_SUBTRACT: begin
               state_we = 1'b1;
               if (cur_total >= item_amount_ff) begin
                  total_in = cur_total - item_amount_ff;
               end else begin
                  total_in = '0;
                  under_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               state_we = 1'b1;
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Rate set-up: (scale / interval) / divider equals scale / (interval * divider)
   assign age          = now_ms_ff - cur_last;
   assign interval_eff = (cur_interval == '0) ? 32'd1 : cur_interval;
   assign prod_in      = 48'(interval_eff) * 48'(cur_divider);
   assign gate_in      = in_range && (age <= STALE_MS);

   assign status.skip = !gate_ff || (prod_ff > 48'(RATE_SCALE));

   // Restoring division, one quotient bit a step
   assign divisor = {1'b0, prod_ff[NUM_W-1:0]};
   assign trial   = {rem_ff, quo_ff[NUM_W-1]};

   assign rate_sat = (quo_ff > NUM_W'(RATE_MAX)) ? RATE_MAX : quo_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff <= '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            last_ff[i]     <= '0;
            interval_ff[i] <= '0;
            total_ff[i]    <= '0;
         end
         for (int i = 0; i < DIVIDER_COUNT; i++) begin
            divider_ff[i] <= DIVIDER_RESET;
         end
      end else begin
         now_ms_ff <= now_ms_in;
         if (state_we) begin
            last_ff[idx]     <= last_in;
            interval_ff[idx] <= interval_in;
            total_ff[idx]    <= total_in;
         end
         // drop writes of zero
         if (csr_write_en && csr_data != '0) begin
            unique case (csr_index)
               CSR_DIVIDER_FIRST:  divider_ff[0] <= csr_data;
               CSR_DIVIDER_SECOND: divider_ff[1] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff    <= req_cmd;
         item_sensor_ff <= req_sensor;
         item_amount_ff <= req_amount;
      end
      if (cmd.exec) begin
         under_ff <= under_in;
      end
      if (cmd.load_mul) begin
         prod_ff       <= prod_in;
         gate_ff       <= gate_in;
         count_ff      <= in_range ? cur_total : '0;
         under_hold_ff <= in_range && under_ff;
         rem_ff        <= '0;
         quo_ff        <= RATE_SCALE;
      end
      if (cmd.div_step) begin
         if (trial >= divisor) begin
            rem_ff <= NUM_W'(trial - divisor);
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[NUM_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         rsp_rate_ml_per_s <= status.skip ? '0 : rate_sat;
         rsp_pulse_count   <= count_ff;
         rsp_underflow     <= under_hold_ff;
      end
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the two-sensor flow meter. A local predictor tracks the
// millisecond clock, the per-sensor pulse history and the dividers, and
// works out the one response that each request transfer must produce.
module tb;
   import dfpm_pkg::*;

   // Commands the block leaves unused: they must change nothing
   localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
   localparam logic [2:0]  CMD_UNUSED_MID = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

   localparam logic [31:0] AGE_LIMIT_MS   = 32'd1000;
   localparam logic [31:0] MICRO_SCALE    = 32'd1000000;
   localparam logic [15:0] DIVIDER_START  = 16'd450;
   localparam int          IDLE_PERCENT   = 28;
   localparam int          PRINT_LIMIT    = 100;

   typedef struct packed {
      logic [15:0] rate;
      logic [31:0] pulses;
      logic        underflow;
   } meter_reading_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_cmd;
   logic        req_sensor;
   logic [31:0] req_amount;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_rate_ml_per_s;
   logic [31:0] rsp_pulse_count;
   logic        rsp_underflow;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_data;

   // Predictor state: clock, per-sensor history and the live dividers
   logic [31:0] meter_ms;
   logic [31:0] last_pulse_at [2];
   logic [31:0] pulse_gap [2];
   logic [31:0] pulse_tally [2];
   logic [15:0] divider_now [2];

   meter_reading_type readings_due [$];
   meter_reading_type oldest_due;
   int unsigned       mismatch_count;
   bit                idle_on;

   dual_flow_pulse_meter_top #(
      .SENSOR_COUNT(2)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_sensor        (req_sensor),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rate_ml_per_s (rsp_rate_ml_per_s),
      .rsp_pulse_count   (rsp_pulse_count),
      .rsp_underflow     (rsp_underflow),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Rate of one sensor as things stand: zero once the last pulse is more
   // than a second old, otherwise scale by interval then by divider, clipped
   function automatic logic [15:0] flow_rate(input logic sens);
      logic [31:0] age;
      logic [31:0] gap;
      logic [31:0] quotient;
      age = meter_ms - last_pulse_at[sens];
      if (age > AGE_LIMIT_MS)
         return '0;
      gap = (pulse_gap[sens] == '0) ? 32'd1 : pulse_gap[sens];
      quotient = (MICRO_SCALE / gap) / {16'd0, divider_now[sens]};
      return (quotient > 32'h0000_FFFF) ? 16'hFFFF : quotient[15:0];
   endfunction

   // Advance the predictor by one request and return what it must answer
   function automatic meter_reading_type step_meter(input logic [2:0] cmd, input logic sens,
                                                    input logic [31:0] amt);
      meter_reading_type r;
      r.underflow = 1'b0;
      if (cmd == CMD_TICK)
         meter_ms = meter_ms + 32'd1;
      case (cmd)
         CMD_PULSE: begin
            pulse_tally[sens]   = pulse_tally[sens] + 32'd1;
            pulse_gap[sens]     = meter_ms - last_pulse_at[sens];
            last_pulse_at[sens] = meter_ms;
         end
         CMD_SUBTRACT: begin
            if (pulse_tally[sens] >= amt) begin
               pulse_tally[sens] = pulse_tally[sens] - amt;
            end else begin
               pulse_tally[sens] = '0;
               r.underflow       = 1'b1;
            end
         end
         CMD_CLEAR: begin
            pulse_tally[sens] = '0;
         end
         default: begin
         end
      endcase
      r.rate   = flow_rate(sens);
      r.pulses = pulse_tally[sens];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   // Offer one request; idle first at random with junk on the payload, then
   // hold the payload until the transfer and log its expected response
   task automatic send_request(input logic [2:0] cmd, input logic sens,
                               input logic [31:0] amt);
      @(negedge clock);
      while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid  <= 1'b0;
         req_cmd    <= 3'($urandom);
         req_sensor <= 1'($urandom);
         req_amount <= $urandom;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_sensor <= sens;
      req_amount <= amt;
      do
         @(posedge clock);
      while (req_stall);
      readings_due.push_back(step_meter(cmd, sens, amt));
   endtask

   // Drop valid and wait until every outstanding response has been taken
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (readings_due.size() != 0)
         @(posedge clock);
   endtask

   // Only call with the block drained; a zero write must leave the old value
   task automatic write_divider(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (value != '0)
         divider_now[idx] = value;
   endtask

   // Random request, weighted towards ticks and pulses so rates stay live;
   // subtract amounts straddle the current count, span the full range or stay small
   task automatic pick_request(output logic [2:0] cmd, output logic sens,
                               output logic [31:0] amt);
      int unsigned roll;
      int unsigned amt_roll;
      roll     = $urandom_range(99);
      amt_roll = $urandom_range(99);
      sens     = 1'($urandom);
      if (roll < 35)
         cmd = CMD_TICK;
      else if (roll < 60)
         cmd = CMD_PULSE;
      else if (roll < 72)
         cmd = CMD_READ;
      else if (roll < 86)
         cmd = CMD_SUBTRACT;
      else if (roll < 93)
         cmd = CMD_CLEAR;
      else
         cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      if (amt_roll < 50)
         amt = $urandom_range(pulse_tally[sens] + 32'd2);
      else if (amt_roll < 75)
         amt = $urandom;
      else
         amt = $urandom_range(3);
   endtask

   // Fresh out of reset the last pulse counts as now, so the rate is live
   task automatic test_after_reset();
      send_request(CMD_READ, 1'b0, '0);
      send_request(CMD_READ, 1'b1, 32'hFFFF_FFFF);
      send_request(CMD_TICK, 1'b1, '0);
   endtask

   task automatic test_each_command();
      send_request(CMD_PULSE, 1'b0, '0);
      // back-to-back pulses with no tick: interval zero counts as one
      send_request(CMD_PULSE, 1'b0, '0);
      repeat (3) send_request(CMD_TICK, 1'b0, '0);
      send_request(CMD_PULSE, 1'b0, '0);
      send_request(CMD_READ, 1'b0, '0);
      send_request(CMD_SUBTRACT, 1'b0, 32'd1);
      // exact subtract reaches zero without underflow
      send_request(CMD_SUBTRACT, 1'b0, 32'd2);
      send_request(CMD_SUBTRACT, 1'b0, '0);
      send_request(CMD_PULSE, 1'b1, '0);
      send_request(CMD_SUBTRACT, 1'b1, 32'hFFFF_FFFF);
      send_request(CMD_PULSE, 1'b1, '0);
      send_request(CMD_SUBTRACT, 1'b1, 32'h8000_0000);
      send_request(CMD_PULSE, 1'b1, '0);
      send_request(CMD_CLEAR, 1'b1, 32'h5555_AAAA);
      send_request(CMD_UNUSED_LO, 1'b0, 32'hFFFF_FFFF);
      send_request(CMD_UNUSED_MID, 1'b1, '0);
      send_request(CMD_UNUSED_HI, 1'b0, 32'd7);
   endtask

   // Walk the dividers through a zero write, the extremes and the
   // saturation knee (15 still clips at interval one, 16 does not)
   task automatic test_divider_settings();
      logic [15:0] first_set [7];
      logic [15:0] second_set [7];
      logic [2:0]  cmd;
      logic        sens;
      logic [31:0] amt;
      first_set  = '{16'd0, 16'd1, 16'd15, 16'hFFFF, 16'd0, 16'hAAAA, DIVIDER_START};
      second_set = '{16'd0, 16'd16, 16'd1, 16'hFFFF, 16'd0, 16'h5555, DIVIDER_START};
      first_set[4]  = 16'($urandom_range(16'hFFFF, 1));
      second_set[4] = 16'($urandom_range(16'hFFFF, 1));
      foreach (first_set[i]) begin
         drain_responses();
         write_divider(CSR_DIVIDER_FIRST, first_set[i]);
         write_divider(CSR_DIVIDER_SECOND, second_set[i]);
         send_request(CMD_PULSE, 1'b0, '0);
         send_request(CMD_PULSE, 1'b1, '0);
         repeat (18) begin
            pick_request(cmd, sens, amt);
            send_request(cmd, sens, amt);
         end
      end
   endtask

   // Age sensor zero to exactly the limit, then one tick past it, while random
   // traffic that never pulses sensor zero goes on; no idling for the first part
   task automatic test_stale_boundary();
      logic [2:0]  cmd;
      logic        sens;
      logic [31:0] amt;
      int unsigned sent;
      sent = 0;
      drain_responses();
      write_divider(CSR_DIVIDER_FIRST, 16'd1);
      idle_on = 1'b0;
      send_request(CMD_PULSE, 1'b0, '0);
      while (meter_ms - last_pulse_at[0] < AGE_LIMIT_MS) begin
         if ($urandom_range(99) < 12) begin
            pick_request(cmd, sens, amt);
            // hold sensor zero quiet; redirect its pulses to sensor one
            if (cmd == CMD_PULSE)
               sens = 1'b1;
         end else begin
            cmd  = CMD_TICK;
            sens = 1'($urandom);
            amt  = $urandom;
         end
         send_request(cmd, sens, amt);
         sent++;
         if (sent == 400)
            idle_on = 1'b1;
      end
      idle_on = 1'b1;
      send_request(CMD_READ, 1'b0, '0);
      send_request(CMD_TICK, 1'b0, '0);
      send_request(CMD_READ, 1'b0, '0);
      // interval past the limit still gives a live, small rate
      send_request(CMD_PULSE, 1'b0, '0);
      send_request(CMD_READ, 1'b0, '0);
   endtask

   // Mixed traffic, with one full pause halfway so the pipe empties
   task automatic test_random_traffic();
      logic [2:0]  cmd;
      logic        sens;
      logic [31:0] amt;
      drain_responses();
      write_divider(CSR_DIVIDER_FIRST, 16'($urandom_range(40, 1)));
      write_divider(CSR_DIVIDER_SECOND, 16'($urandom_range(40, 1)));
      for (int n = 0; n < 150; n++) begin
         if (n == 75)
            drain_responses();
         pick_request(cmd, sens, amt);
         send_request(cmd, sens, amt);
      end
   endtask

   // Take stall decisions at the falling edge so the transfer is settled
   // before the next rising edge samples it
   always @(negedge clock)
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            report_mismatch("unsolicited response, count", rsp_pulse_count, '0);
         end else begin
            oldest_due = readings_due.pop_front();
            if (rsp_rate_ml_per_s !== oldest_due.rate)
               report_mismatch("rate", 32'(rsp_rate_ml_per_s), 32'(oldest_due.rate));
            if (rsp_pulse_count !== oldest_due.pulses)
               report_mismatch("pulse count", rsp_pulse_count, oldest_due.pulses);
            if (rsp_underflow !== oldest_due.underflow)
               report_mismatch("underflow", 32'(rsp_underflow), 32'(oldest_due.underflow));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_READ;
      req_sensor     = 1'b0;
      req_amount     = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_DIVIDER_FIRST;
      csr_data       = '0;
      idle_on        = 1'b1;
      mismatch_count = 0;
      meter_ms       = '0;
      for (int s = 0; s < 2; s++) begin
         last_pulse_at[s] = '0;
         pulse_gap[s]     = '0;
         pulse_tally[s]   = '0;
         divider_now[s]   = DIVIDER_START;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_each_command();
      test_divider_settings();
      test_stale_boundary();
      test_random_traffic();

      // Let the last responses arrive, then allow for the longest latency
      drain_responses();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("** dual_flow_pulse_meter_top: PASSED **");
      else
         $display("** dual_flow_pulse_meter_top: FAILED **");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("** dual_flow_pulse_meter_top: FAILED **");
      $finish;
   end

endmodule
